// ===== design/s2da_pkg.sv =====
package s2da_pkg;

    localparam int DEFAULT_VALUE_BITS = 64;
    localparam int DEFAULT_MAX_CHARS  = 20;

    // Magnitude bits folded into the BCD register per conversion cycle
    localparam int BITS_PER_STEP = 4;

    localparam int CHAR_W    = 7;
    localparam int LEN_W     = 5;
    localparam int BUF_LEN_W = 7;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 3;

    localparam logic [BUF_LEN_W-1:0] BUF_LEN_RESET = 7'd50;
    localparam logic [CHAR_W-1:0]    CHAR_ZERO     = 7'h30;
    localparam logic [CHAR_W-1:0]    CHAR_MINUS    = 7'h2D;

    // Register index decoded from paddr[2]
    localparam logic REG_BUF_LEN = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_COUNT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic shift;
        logic count;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic last_shift;
        logic out_free;
        logic last_char;
    } stat_t;

endpackage

// ===== design/s2da_ctrl.sv =====
module s2da_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  s2da_pkg::stat_t stat,
    output s2da_pkg::cmd_t  cmd
);

    s2da_pkg::state_t state_reg;
    s2da_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= s2da_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            s2da_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = s2da_pkg::ST_CONVERT;
                end
            end
            s2da_pkg::ST_CONVERT: begin
                cmd.shift = 1'b1;
                if (stat.last_shift) begin
                    state_next = s2da_pkg::ST_COUNT;
                end
            end
            s2da_pkg::ST_COUNT: begin
                cmd.count  = 1'b1;
                state_next = s2da_pkg::ST_EMIT;
            end
            s2da_pkg::ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit = 1'b1;
                    if (stat.last_char) begin
                        state_next = s2da_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = s2da_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/s2da_datapath.sv =====
module s2da_datapath #(
    parameter int VALUE_BITS = s2da_pkg::DEFAULT_VALUE_BITS,
    parameter int MAX_CHARS  = s2da_pkg::DEFAULT_MAX_CHARS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  s2da_pkg::cmd_t                      cmd,
    output s2da_pkg::stat_t                     stat,
    input  logic signed [VALUE_BITS-1:0]        s_value,
    input  logic [s2da_pkg::BUF_LEN_W-1:0]      buf_len,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [s2da_pkg::CHAR_W-1:0]         m_out_char,
    output logic                                m_out_last,
    output logic [s2da_pkg::LEN_W-1:0]          m_out_length
);

    localparam int STEP     = s2da_pkg::BITS_PER_STEP;
    localparam int STEPS    = (VALUE_BITS + STEP - 1) / STEP;
    localparam int PAD_BITS = STEPS * STEP;
    localparam int STEP_W   = $clog2(STEPS);
    localparam int DIGITS   = MAX_CHARS - 1;
    localparam int BCD_W    = DIGITS * 4;
    localparam int DIG_W    = $clog2(DIGITS);
    localparam int LEN_W    = s2da_pkg::LEN_W;
    localparam int BL_W     = s2da_pkg::BUF_LEN_W;

    logic [PAD_BITS-1:0]    mag_reg,  mag_next;
    logic [BCD_W-1:0]       bcd_reg,  bcd_next;
    logic                   ovf_reg,  ovf_next;
    logic                   neg_reg,  neg_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [DIG_W-1:0]       idx_reg,  idx_next;
    logic [LEN_W-1:0]       rem_reg,  rem_next;
    logic [LEN_W-1:0]       len_reg,  len_next;
    logic                   sign_reg, sign_next;

    logic                        m_valid_reg,  m_valid_next;
    logic [s2da_pkg::CHAR_W-1:0] char_reg,     char_next;
    logic                        last_reg,     last_next;
    logic [LEN_W-1:0]            olen_reg,     olen_next;

    logic [VALUE_BITS-1:0]  abs_val;
    logic [PAD_BITS-1:0]    mag_sh;
    logic [BCD_W-1:0]       bcd_sh;
    logic                   ovf_sh;
    logic [LEN_W-1:0]       sig;
    logic [BL_W-1:0]        lim;
    logic [LEN_W-1:0]       nd;
    logic [3:0]             cur_digit;

    assign abs_val = s_value[VALUE_BITS-1] ? (~s_value + 1'b1) : s_value;

    // Shift-and-add-3 conversion, several magnitude bits per cycle
    always_comb begin
        mag_sh = mag_reg;
        bcd_sh = bcd_reg;
        ovf_sh = ovf_reg;
        for (int b = 0; b < STEP; b++) begin
            for (int d = 0; d < DIGITS; d++) begin
                if (bcd_sh[4*d +: 4] >= 4'd5) begin
                    bcd_sh[4*d +: 4] = bcd_sh[4*d +: 4] + 4'd3;
                end
            end
            ovf_sh = ovf_sh | bcd_sh[BCD_W-1];
            bcd_sh = {bcd_sh[BCD_W-2:0], mag_sh[PAD_BITS-1]};
            mag_sh = {mag_sh[PAD_BITS-2:0], 1'b0};
        end
    end

    // Significant digit count, then clamp to the buffer limit
    always_comb begin
        sig = LEN_W'(1);
        for (int d = 0; d < DIGITS; d++) begin
            if (bcd_reg[4*d +: 4] != 4'd0) begin
                sig = LEN_W'(d + 1);
            end
        end
        if (ovf_reg) begin
            sig = LEN_W'(DIGITS);
        end
        lim = (buf_len > BL_W'(3)) ? (buf_len - BL_W'(2)) : BL_W'(1);
        if (lim > BL_W'(DIGITS)) begin
            lim = BL_W'(DIGITS);
        end
        nd = (BL_W'(sig) > lim) ? LEN_W'(lim) : sig;
    end

    assign cur_digit = bcd_reg[4*idx_reg +: 4];

    always_comb begin
        mag_next  = mag_reg;
        bcd_next  = bcd_reg;
        ovf_next  = ovf_reg;
        neg_next  = neg_reg;
        step_next = step_reg;
        idx_next  = idx_reg;
        rem_next  = rem_reg;
        len_next  = len_reg;
        sign_next = sign_reg;
        char_next = char_reg;
        last_next = last_reg;
        olen_next = olen_reg;
        m_valid_next = m_valid_reg & ~m_ready;

        if (cmd.load) begin
            neg_next  = s_value[VALUE_BITS-1];
            mag_next  = PAD_BITS'(abs_val);
            bcd_next  = '0;
            ovf_next  = 1'b0;
            step_next = '0;
        end
        if (cmd.shift) begin
            mag_next  = mag_sh;
            bcd_next  = bcd_sh;
            ovf_next  = ovf_sh;
            step_next = step_reg + 1'b1;
        end
        if (cmd.count) begin
            idx_next  = DIG_W'(nd - 1'b1);
            len_next  = nd + LEN_W'(neg_reg);
            rem_next  = nd + LEN_W'(neg_reg);
            sign_next = neg_reg;
        end
        if (cmd.emit) begin
            m_valid_next = 1'b1;
            last_next    = (rem_reg == LEN_W'(1));
            olen_next    = len_reg;
            rem_next     = rem_reg - 1'b1;
            if (sign_reg) begin
                char_next = s2da_pkg::CHAR_MINUS;
                sign_next = 1'b0;
            end else begin
                char_next = s2da_pkg::CHAR_ZERO + {3'b000, cur_digit};
                idx_next  = idx_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg  <= mag_next;
        bcd_reg  <= bcd_next;
        ovf_reg  <= ovf_next;
        neg_reg  <= neg_next;
        step_reg <= step_next;
        idx_reg  <= idx_next;
        rem_reg  <= rem_next;
        len_reg  <= len_next;
        sign_reg <= sign_next;
        char_reg <= char_next;
        last_reg <= last_next;
        olen_reg <= olen_next;
    end

    assign stat.last_shift = (step_reg == STEP_W'(STEPS - 1));
    assign stat.out_free   = ~m_valid_reg | m_ready;
    assign stat.last_char  = (rem_reg == LEN_W'(1));

    assign m_valid      = m_valid_reg;
    assign m_out_char   = char_reg;
    assign m_out_last   = last_reg;
    assign m_out_length = olen_reg;

endmodule

// ===== design/signed_to_decimal_ascii.sv =====
// Sequence: a load, the 4-bit-per-cycle binary-to-BCD shift loop, a count step, then the
// characters move to the output register one a cycle while that register is free.
// A new value is taken only after the last character of the previous text has moved to
// the output register.
// Reset: aresetn synchronous, active low; clears control state, buffer_length goes to 50.
module signed_to_decimal_ascii #(
    parameter int VALUE_BITS = s2da_pkg::DEFAULT_VALUE_BITS,
    parameter int MAX_CHARS  = s2da_pkg::DEFAULT_MAX_CHARS
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    // Configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [s2da_pkg::ADDR_W-1:0]       paddr,
    input  logic [s2da_pkg::DATA_W-1:0]       pwdata,
    output logic [s2da_pkg::DATA_W-1:0]       prdata,
    output logic                              pready,

    // Request channel: one signed value
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [VALUE_BITS-1:0]      s_value,

    // Result channel: one character per transfer
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [s2da_pkg::CHAR_W-1:0]       m_out_char,
    output logic                              m_out_last,
    output logic [s2da_pkg::LEN_W-1:0]        m_out_length
);

    localparam int BL_W = s2da_pkg::BUF_LEN_W;

    logic [BL_W-1:0] buf_len_reg;
    logic [BL_W-1:0] buf_len_next;
    logic            reg_sel;

    s2da_pkg::cmd_t  cmd;
    s2da_pkg::stat_t stat;

    // Single register at word 0; byte offset bits are don't-care.
    assign reg_sel = (paddr[2] == s2da_pkg::REG_BUF_LEN);
    assign pready  = 1'b1;

    always_comb begin
        buf_len_next = buf_len_reg;
        if (psel && penable && pwrite && reg_sel) begin
            buf_len_next = pwdata[BL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_len_reg <= s2da_pkg::BUF_LEN_RESET;
        end else begin
            buf_len_reg <= buf_len_next;
        end
    end

    // Read back the buffer length; anything else reads as zero
    assign prdata = reg_sel ? {{(s2da_pkg::DATA_W - BL_W){1'b0}}, buf_len_reg} : '0;

    // Sequencer: accept a request only when idle, then convert, size the text and
    // hand characters to the output register as it frees up. The final character
    // may still wait in that register while the next request is taken.
    s2da_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Datapath: magnitude and sign capture, BCD conversion, digit count with
    // truncation to the buffer limit, and the output register.
    s2da_datapath #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_CHARS  (MAX_CHARS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .s_value      (s_value),
        .buf_len      (buf_len_reg),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_char   (m_out_char),
        .m_out_last   (m_out_last),
        .m_out_length (m_out_length)
    );

endmodule

// ===== dv/signed_to_decimal_ascii_tb.sv =====
module signed_to_decimal_ascii_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VALUE_BITS = s2da_pkg::DEFAULT_VALUE_BITS;
    localparam int MAX_CHARS  = s2da_pkg::DEFAULT_MAX_CHARS;

    // Byte address of the buffer length register: index in bit 2, word aligned
    localparam logic [s2da_pkg::ADDR_W-1:0] BUF_LEN_ADDR = {s2da_pkg::REG_BUF_LEN, 2'b00};

    localparam logic [VALUE_BITS-1:0] MIN_VALUE = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam logic [VALUE_BITS-1:0] MAX_VALUE = {1'b0, {(VALUE_BITS-1){1'b1}}};

    // Receiver hold-off used to back the block up into its request port
    localparam int SINK_HOLD_CYCLES = 400;
    // Quiet cycles after the last character before the run closes
    localparam int TAIL_CYCLES      = 40;
    // Watchdog: limit on the whole run in ns; the clock period is 2 ns
    localparam int WATCHDOG_NS      = 2_000_000;

    // One character of expected text, as it should appear on the result port
    typedef struct packed {
        logic [s2da_pkg::CHAR_W-1:0] ch;
        logic                        last;
        logic [s2da_pkg::LEN_W-1:0]  length;
    } text_char_t;

    // Directed row: buffer length in force, value to convert, and the text
    // where it is obvious by inspection (empty means use the predictor)
    typedef struct {
        logic [s2da_pkg::BUF_LEN_W-1:0] buf_len;
        logic [VALUE_BITS-1:0]          value;
        string                          text;
    } text_case_t;

    logic                     aclk    = 1'b0;
    logic                     aresetn = 1'b0;

    logic                            psel    = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite  = 1'b0;
    logic [s2da_pkg::ADDR_W-1:0]     paddr   = '0;
    logic [s2da_pkg::DATA_W-1:0]     pwdata  = '0;
    logic [s2da_pkg::DATA_W-1:0]     prdata;
    logic                            pready;

    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic signed [VALUE_BITS-1:0] s_value = '0;

    logic                            m_valid;
    logic                            m_ready = 1'b0;
    logic [s2da_pkg::CHAR_W-1:0]     m_out_char;
    logic                            m_out_last;
    logic [s2da_pkg::LEN_W-1:0]      m_out_length;

    // Characters still owed by the block, oldest first
    text_char_t                      pending_chars[$];
    logic [s2da_pkg::BUF_LEN_W-1:0]  buf_len_now = s2da_pkg::BUF_LEN_RESET;

    bit                       sender_idles  = 1'b0;
    bit                       sink_idles    = 1'b0;
    bit                       sink_hold_req = 1'b0;

    int                       fail_count      = 0;
    int                       values_sent     = 0;
    int                       negatives_sent  = 0;
    int                       chars_checked   = 0;
    int                       settings_used   = 0;

    text_case_t text_cases[24] = '{
        // reset buffer length: full text, both extremes, sign handling
        '{7'd50,  64'd0,                  "0"},
        '{7'd50,  64'd7,                  "7"},
        '{7'd50,  -64'sd1,                "-1"},
        '{7'd50,  64'd10,                 "10"},
        '{7'd50,  -64'sd10,               "-10"},
        '{7'd50,  MAX_VALUE,              "9223372036854775807"},
        '{7'd50,  MIN_VALUE,              "-9223372036854775808"},
        '{7'd50,  64'd1234567890,         ""},
        '{7'd50,  -64'sd987654321,        ""},
        '{7'd50,  64'h5555_5555_5555_5555, ""},
        // limit of 18 digits: the top digit of a 19-digit value drops
        '{7'd20,  MIN_VALUE,              "-223372036854775808"},
        '{7'd20,  MAX_VALUE,              "223372036854775807"},
        // truncated text keeps leading zeros of the low digits
        '{7'd4,   64'd1005,               "05"},
        '{7'd4,   -64'sd1005,             "-05"},
        '{7'd4,   64'd99,                 "99"},
        // small buffers collapse to a single digit
        '{7'd3,   -64'sd123,              "-3"},
        '{7'd3,   64'd0,                  "0"},
        '{7'd1,   64'd98,                 "8"},
        '{7'd1,   MIN_VALUE,              "-8"},
        '{7'd0,   64'd12,                 "2"},
        // large buffers are capped below the character limit; buffer 5 keeps three digits
        '{7'd127, MAX_VALUE,              "9223372036854775807"},
        '{7'd64,  MIN_VALUE,              "-9223372036854775808"},
        '{7'd5,   64'd100000,             "000"},
        '{7'd5,   -64'sd100,              "-100"}
    };

    signed_to_decimal_ascii dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_char   (m_out_char),
        .m_out_last   (m_out_last),
        .m_out_length (m_out_length)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Compute the decimal text the block should emit for one value
    function automatic string decimal_text(input logic [VALUE_BITS-1:0] value,
                                           input logic [s2da_pkg::BUF_LEN_W-1:0] buf_len);
        logic        neg;
        logic [63:0] mag;
        int          limit;
        int          ndigits;
        string       digits;
        neg     = value[VALUE_BITS-1];
        // two's complement negate in unsigned math handles the minimum value
        mag     = neg ? (~value + 64'd1) : value;
        limit   = (buf_len > 7'd3) ? int'(buf_len) - 2 : 1;
        if (limit > MAX_CHARS - 1)
            limit = MAX_CHARS - 1;
        digits  = "";
        ndigits = 0;
        do begin
            digits  = $sformatf("%0d%s", mag % 64'd10, digits);
            mag     = mag / 64'd10;
            ndigits++;
        end while (mag != 64'd0 && ndigits < limit);
        return neg ? {"-", digits} : digits;
    endfunction

    // Queue one character per position, flag the final one, stamp the length
    function automatic void queue_text(input string text);
        text_char_t c;
        for (int i = 0; i < text.len(); i++) begin
            c.ch     = s2da_pkg::CHAR_W'(text[i]);
            c.last   = (i == text.len() - 1);
            c.length = s2da_pkg::LEN_W'(text.len());
            pending_chars.push_back(c);
        end
    endfunction

    function automatic logic [63:0] power_of_ten(input int k);
        logic [63:0] p;
        p = 64'd1;
        repeat (k) p = p * 64'd10;
        return p;
    endfunction

    // Mix of full-width noise, chosen digit counts, boundaries and round numbers
    function automatic logic [VALUE_BITS-1:0] random_value();
        logic [63:0] raw;
        logic [63:0] scale;
        logic [63:0] picked;
        bit          flip;
        raw   = {$urandom, $urandom};
        scale = power_of_ten($urandom_range(0, 18));
        flip  = 1'b0;
        case (int'($urandom_range(0, 9)))
            0, 1, 2: picked = raw;
            3, 4, 5: begin
                // exact digit count given by the scale
                picked = scale + raw % (scale * 64'd9);
                flip   = $urandom_range(0, 1);
            end
            6: picked = 64'($urandom_range(0, 2000)) - 64'd1000;
            7: begin
                // straddle a power of ten
                picked = scale + 64'($urandom_range(0, 2)) - 64'd1;
                flip   = $urandom_range(0, 1);
            end
            8: picked = raw[0] ? MIN_VALUE + 64'($urandom_range(0, 20))
                               : MAX_VALUE - 64'($urandom_range(0, 20));
            default: begin
                // round numbers: long runs of trailing zeros
                picked = 64'($urandom_range(1, 99)) * power_of_ten($urandom_range(0, 16));
                flip   = $urandom_range(0, 1);
            end
        endcase
        if (flip)
            picked = -picked;
        return picked;
    endfunction

    // Offer one request, hold it until accepted, then record its text
    task automatic send_value(input logic [VALUE_BITS-1:0] value, input string text);
        if (sender_idles && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= value;
        do @(posedge aclk); while (!s_ready);
        queue_text((text == "") ? decimal_text(value, buf_len_now) : text);
        values_sent++;
        if (value[VALUE_BITS-1])
            negatives_sent++;
    endtask

    // Drop valid and wait until every owed character has come out
    task automatic wait_text_drained();
        s_valid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Setup cycle, then access cycle; the register takes the value on pready
    task automatic write_buffer_length(input logic [s2da_pkg::BUF_LEN_W-1:0] buf_len);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= BUF_LEN_ADDR;
        pwdata  <= s2da_pkg::DATA_W'(buf_len);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        buf_len_now = buf_len;
        settings_used++;
    endtask

    // One random phase at a fixed buffer length, optionally with a long sink stall
    task automatic run_phase(input logic [s2da_pkg::BUF_LEN_W-1:0] buf_len,
                             input int n_values, input bit idles, input bit with_hold);
        wait_text_drained();
        write_buffer_length(buf_len);
        sender_idles = idles;
        sink_idles   = idles;
        for (int i = 0; i < n_values; i++) begin
            // stall the receiver early and keep offering requests behind it
            if (with_hold && i == 5)
                sink_hold_req = 1'b1;
            send_value(random_value(), "");
        end
    endtask

    // Receiver pacing: long hold on request, random stall bursts, else ready
    initial begin : sink_pacing
        @(posedge aclk);
        forever begin
            if (sink_hold_req) begin
                m_ready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge aclk);
                sink_hold_req = 1'b0;
            end else if (sink_idles && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // Compare each accepted character against the oldest owed one
    always @(posedge aclk) begin : char_check
        text_char_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_chars.size() == 0) begin
                $error("unexpected character 0x%0h with no request outstanding", m_out_char);
                fail_count++;
            end else begin
                want = pending_chars.pop_front();
                chars_checked++;
                if (m_out_char !== want.ch) begin
                    $error("out_char: expected 0x%0h, got 0x%0h", want.ch, m_out_char);
                    fail_count++;
                end
                if (m_out_last !== want.last) begin
                    $error("out_last: expected %0d, got %0d", want.last, m_out_last);
                    fail_count++;
                end
                if (m_out_length !== want.length) begin
                    $error("out_length: expected %0d, got %0d", want.length, m_out_length);
                    fail_count++;
                end
            end
        end
    end

    initial begin : stimulus
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table; the first rows run on the reset buffer length
        sender_idles = 1'b1;
        sink_idles   = 1'b1;
        foreach (text_cases[i]) begin
            if (text_cases[i].buf_len != buf_len_now) begin
                wait_text_drained();
                write_buffer_length(text_cases[i].buf_len);
            end
            send_value(text_cases[i].value, text_cases[i].text);
        end

        // Random phases across the buffer length range
        run_phase(7'd50,  45, 1'b1, 1'b1);
        run_phase(7'd64,  45, 1'b1, 1'b0);
        run_phase(7'd1,   35, 1'b1, 1'b0);
        run_phase(7'd4,   45, 1'b1, 1'b0);
        run_phase(7'd0,   20, 1'b1, 1'b0);
        run_phase(7'd127, 20, 1'b1, 1'b0);
        run_phase(7'd12,  45, 1'b1, 1'b0);
        run_phase(7'd20,  45, 1'b1, 1'b0);
        run_phase(7'd21,  35, 1'b1, 1'b0);
        run_phase(7'd3,   25, 1'b1, 1'b0);
        run_phase(s2da_pkg::BUF_LEN_W'($urandom_range(1, 64)), 40, 1'b1, 1'b0);
        // close at full rate on both sides
        run_phase(7'd50,  40, 1'b0, 1'b0);

        wait_text_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Converted %0d values (%0d negative) under %0d buffer length settings,",
                 values_sent, negatives_sent, settings_used);
        $display("checked %0d characters with random stalls on both ports.", chars_checked);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin : watchdog
        #(WATCHDOG_NS);
        $display("timeout: %0d characters still owed", pending_chars.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
